FILE: rtl/md5_pkg.sv
// shared types, constants and round tables for the md5 hash engine
`timescale 1ns / 1ps

package md5_pkg;

  localparam int WordW  = 32;
  localparam int Words  = 16;
  localparam int WordAw = 4;
  localparam int CountW = 61;

  localparam logic [1:0] ReqAppend       = 2'd0;
  localparam logic [1:0] ReqAppendFinish = 2'd1;
  localparam logic [1:0] ReqFinish       = 2'd2;

  localparam logic [7:0] PadByte = 8'h80;

  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
  } md5_abcd_t;

  localparam md5_abcd_t Md5Iv = '{
    a: 32'h67452301,
    b: 32'hefcdab89,
    c: 32'h98badcfe,
    d: 32'h10325476
  };

  function automatic logic [WordW-1:0] md5_round_const(input logic [5:0] i);
    logic [WordW-1:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_rot_amt(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

  // message word index used by round i
  function automatic logic [WordAw-1:0] md5_msg_idx(input logic [5:0] i);
    logic [WordAw-1:0] lo;
    logic [WordAw-1:0] g;
    lo = i[3:0];
    case (i[5:4])
      2'd0:    g = lo;
      2'd1:    g = (lo * 4'd5) + 4'd1;
      2'd2:    g = (lo * 4'd3) + 4'd5;
      default: g = lo * 4'd7;
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/md5_hash_engine_core.sv
// md5 hash engine top level: byte intake, padding sequencer and round loop
//
//   channel  | dir | tdata                          | tuser
//   in_      | in  | [7:0] data_byte                | [1:0] req_type
//   out_     | out | [63:0] digest_low, [127:64] hi | -
//
// an append byte that does not close a block leaves the engine idle; a full
// block is loaded, run for 64 rounds through the one round unit, then folded
// a finish writes the pad words, runs one or two transforms
// and then loads the output register; rate is set by the round loop
// and the single write port of the message word ram
// synchronous active-low reset restores the initial vector and a zero count
// a waiting result does not block byte intake; a second finish waits for it
`timescale 1ns / 1ps

module md5_hash_engine_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic [1:0]   in_tuser,   // [1:0] req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // [63:0] digest_low, [127:64] digest_high
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PREP  = 7'b0000010,
    ST_ROUND = 7'b0000100,
    ST_FOLD  = 7'b0001000,
    ST_PAD1  = 7'b0010000,
    ST_PADZ  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  state_t                  state_r, state_nxt;
  md5_pkg::md5_abcd_t      chain_r, chain_nxt;
  md5_pkg::md5_abcd_t      abcd_r, abcd_nxt;
  md5_pkg::md5_abcd_t      round_out;
  logic [60:0]             byte_total_r, byte_total_nxt;
  logic [31:0]             acc_r, acc_nxt;
  logic [5:0]              rnd_r, rnd_nxt;
  logic [3:0]              wi_r, wi_nxt;
  logic                    fin_r, fin_nxt;
  logic                    padded_r, padded_nxt;
  logic                    long_r, long_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [127:0]            out_tdata_r, out_tdata_nxt;

  logic                    in_fire;
  logic                    emit_go;
  logic [5:0]              pos;
  logic [63:0]             bit_count;
  logic [31:0]             partial_word;
  logic                    ram_we;
  logic [3:0]              ram_waddr;
  logic [31:0]             ram_wdata;
  logic [3:0]              ram_raddr;
  logic [31:0]             ram_rdata;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign emit_go    = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign pos        = byte_total_r[5:0];
  assign bit_count  = {byte_total_r, 3'b000};

  md5_ram #(
    .WIDTH (32),
    .DEPTH (16)
  ) u_words (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  md5_round u_round (
    .cur (abcd_r),
    .w   (ram_rdata),
    .rnd (rnd_r),
    .nxt (round_out)
  );

  // current partial word closed with the pad byte
  always_comb begin
    case (pos[1:0])
      2'd0:    partial_word = {24'h0, md5_pkg::PadByte};
      2'd1:    partial_word = {16'h0, md5_pkg::PadByte, acc_r[31:24]};
      2'd2:    partial_word = {8'h0, md5_pkg::PadByte, acc_r[31:16]};
      default: partial_word = {md5_pkg::PadByte, acc_r[31:8]};
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    chain_nxt      = chain_r;
    abcd_nxt       = abcd_r;
    byte_total_nxt = byte_total_r;
    acc_nxt        = acc_r;
    rnd_nxt        = rnd_r;
    wi_nxt         = wi_r;
    fin_nxt        = fin_r;
    padded_nxt     = padded_r;
    long_nxt       = long_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    ram_we         = 1'b0;
    ram_waddr      = wi_r;
    ram_wdata      = '0;
    ram_raddr      = md5_pkg::md5_msg_idx(rnd_r + 6'd1);

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_tuser) inside
            md5_pkg::ReqAppend, md5_pkg::ReqAppendFinish: begin
              acc_nxt        = {in_tdata, acc_r[31:8]};
              byte_total_nxt = byte_total_r + 61'd1;
              fin_nxt        = (in_tuser == md5_pkg::ReqAppendFinish);
              if (pos[1:0] == 2'd3) begin
                ram_we    = 1'b1;
                ram_waddr = pos[5:2];
                ram_wdata = {in_tdata, acc_r[31:8]};
              end
              if (pos == 6'd63) begin
                state_nxt = ST_PREP;
              end else if (in_tuser == md5_pkg::ReqAppendFinish) begin
                state_nxt = ST_PAD1;
              end
            end
            md5_pkg::ReqFinish: begin
              fin_nxt   = 1'b1;
              state_nxt = ST_PAD1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PREP: begin
        ram_raddr = md5_pkg::md5_msg_idx(6'd0);
        abcd_nxt  = chain_r;
        rnd_nxt   = 6'd0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        abcd_nxt = round_out;
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        chain_nxt.a = chain_r.a + abcd_r.a;
        chain_nxt.b = chain_r.b + abcd_r.b;
        chain_nxt.c = chain_r.c + abcd_r.c;
        chain_nxt.d = chain_r.d + abcd_r.d;
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (!padded_r) begin
          state_nxt = ST_PAD1;
        end else if (long_r) begin
          long_nxt  = 1'b0;
          wi_nxt    = 4'd0;
          state_nxt = ST_PADZ;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_PAD1: begin
        padded_nxt = 1'b1;
        long_nxt   = (pos[5:3] == 3'b111);
        ram_we     = 1'b1;
        ram_waddr  = pos[5:2];
        ram_wdata  = partial_word;
        wi_nxt     = pos[5:2] + 4'd1;
        if (pos[5:2] == 4'd15) begin
          state_nxt = ST_PREP;
        end else begin
          state_nxt = ST_PADZ;
        end
      end
      ST_PADZ: begin
        ram_we = 1'b1;
        if (!long_r && wi_r == 4'd14) begin
          ram_wdata = bit_count[31:0];
        end else if (!long_r && wi_r == 4'd15) begin
          ram_wdata = bit_count[63:32];
        end
        wi_nxt = wi_r + 4'd1;
        if (wi_r == 4'd15) begin
          state_nxt = ST_PREP;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {chain_r.d, chain_r.c, chain_r.b, chain_r.a};
          chain_nxt      = md5_pkg::Md5Iv;
          byte_total_nxt = '0;
          fin_nxt        = 1'b0;
          padded_nxt     = 1'b0;
          long_nxt       = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      chain_r      <= md5_pkg::Md5Iv;
      byte_total_r <= '0;
      fin_r        <= 1'b0;
      padded_r     <= 1'b0;
      long_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      chain_r      <= chain_nxt;
      byte_total_r <= byte_total_nxt;
      fin_r        <= fin_nxt;
      padded_r     <= padded_nxt;
      long_r       <= long_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    abcd_r      <= abcd_nxt;
    acc_r       <= acc_nxt;
    rnd_r       <= rnd_nxt;
    wi_r        <= wi_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  a_round_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r == 6'd63) |=> (state_r == ST_FOLD))
    else $error("round loop did not end in fold");

  a_emit_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && emit_go) |=>
      (byte_total_r == '0 && chain_r == md5_pkg::Md5Iv && out_tvalid_r))
    else $error("finish did not restore initial vector");

  a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == md5_pkg::ReqAppend) |=>
      (byte_total_r == $past(byte_total_r) + 61'd1))
    else $error("byte count not advanced");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid_r && state_r != ST_EMIT) |=> !out_tvalid_r)
    else $error("result raised outside emit");

endmodule

FILE: rtl/md5_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module md5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: rtl/md5_round.sv
// one md5 round step, shared by all 64 rounds
`timescale 1ns / 1ps

module md5_round (
  input  md5_pkg::md5_abcd_t cur,
  input  logic [31:0]        w,
  input  logic [5:0]         rnd,
  output md5_pkg::md5_abcd_t nxt
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [4:0]  s;
  logic [63:0] dbl;

  always_comb begin
    case (rnd[5:4])
      2'd0:    f = (cur.b & cur.c) | (~cur.b & cur.d);
      2'd1:    f = (cur.b & cur.d) | (cur.c & ~cur.d);
      2'd2:    f = cur.b ^ cur.c ^ cur.d;
      default: f = cur.c ^ (cur.b | ~cur.d);
    endcase
  end

  assign sum = cur.a + f + md5_pkg::md5_round_const(rnd) + w;
  assign s   = md5_pkg::md5_rot_amt(rnd);
  assign dbl = {sum, sum} << s;

  always_comb begin
    nxt.a = cur.d;
    nxt.d = cur.c;
    nxt.c = cur.b;
    nxt.b = cur.b + dbl[63:32];
  end

endmodule
